### sv/quantize_float_to_int8_macros.svh
// Assertion macros used by the quantizer top level.
`ifndef QUANTIZE_FLOAT_TO_INT8_MACROS_SVH
`define QUANTIZE_FLOAT_TO_INT8_MACROS_SVH

// ante implies cons in the same cycle
`define QFI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// ante implies cons a fixed number of cycles later
`define QFI_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("%m: delayed check failed");

`endif

### sv/qfi_pkg.sv
// Types, constants and helpers of the float to int8 quantizer.
package qfi_pkg;

   localparam int EXP_W     = 11;
   localparam int MANT_W    = 24;
   localparam int QUOT_W    = 25;
   localparam int DIV_STEPS = 25;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;
   localparam int VAL_W     = 34;
   localparam int BF16_SHIFT = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNSIGNED = CSR_IDX_W'(3);

   localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

   localparam logic signed [VAL_W-1:0] SIGNED_LOW    = -VAL_W'(128);
   localparam logic signed [VAL_W-1:0] SIGNED_HIGH   = VAL_W'(127);
   localparam logic signed [VAL_W-1:0] UNSIGNED_HIGH = VAL_W'(255);
   localparam logic signed [VAL_W-1:0] SAT_LOW       = -(VAL_W'(64'sd2147483648));
   localparam logic signed [VAL_W-1:0] SAT_HIGH      = VAL_W'(64'sd2147483647);

   typedef enum logic [1:0] {
      FMT_SINGLE = 2'd0,
      FMT_BF16   = 2'd1,
      FMT_HALF   = 2'd2
   } format_type;

   typedef enum logic [1:0] {
      CLS_FINITE,
      CLS_ZERO,
      CLS_SAT
   } class_type;

   typedef struct packed {
      logic [31:0] element_bits;
      logic        final_element;
   } req_type;

   typedef struct packed {
      logic [7:0] quantized_byte;
      logic       final_result;
   } rsp_type;

   typedef struct packed {
      logic [MANT_W-1:0]       mant;
      logic signed [EXP_W-1:0] exponent;
   } norm_type;

   typedef struct packed {
      logic                    valid;
      logic                    final_flag;
      logic                    sign;
      class_type               cls;
      logic signed [EXP_W-1:0] exponent;
      logic [QUOT_W-1:0]       rem;
      logic [MANT_W-1:0]       divisor;
      logic [QUOT_W-1:0]       quot;
   } div_type;

   // unbiased exponent and mantissa with the leading one at the top
   function automatic norm_type normalize(input logic [7:0] ex, input logic [22:0] frac);
      norm_type   r;
      logic [4:0] top;
      logic [4:0] shift;
      top = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (frac[i]) top = 5'(i);
      end
      shift = 5'd23 - top;
      if (ex != 8'd0) begin
         r.mant     = {1'b1, frac};
         r.exponent = $signed({3'b000, ex}) - EXP_W'(127);
      end else begin
         r.mant     = {1'b0, frac} << shift;
         r.exponent = -EXP_W'(126) - $signed({6'd0, shift});
      end
      return r;
   endfunction

endpackage

### sv/quantize_float_to_int8.sv
// Top level of the float to int8 affine quantizer.
// One item per cycle: an item accepted at start passes through two input
// stages, 25 divider steps of one restoring subtract each and three rounding
// and clamping stages before it goes out on rsp_valid. busy is high only
// during reset; results cannot be held off and leave in accept order.
// Configuration writes on the csr_ channel are taken at any time but only
// belong between items.
`include "quantize_float_to_int8_macros.svh"
module quantize_float_to_int8 import qfi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int LATENCY = DIV_STEPS + 5;

   logic [31:0]       scale_ff;
   logic signed [8:0] offset_ff;
   logic [1:0]        format_ff;
   logic              unsigned_ff;
   logic              accept;
   div_type           chain [0:DIV_STEPS];

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= SCALE_RESET;
         offset_ff   <= '0;
         format_ff   <= FMT_SINGLE;
         unsigned_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE:    scale_ff    <= csr_wdata[31:0];
            CSR_OFFSET:   offset_ff   <= $signed(csr_wdata[8:0]);
            CSR_FORMAT:   format_ff   <= csr_wdata[1:0];
            CSR_UNSIGNED: unsigned_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   qfi_unpack u_unpack (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .req_data      (req_data),
      .source_format (format_ff),
      .scale_bits    (scale_ff),
      .out           (chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      qfi_div_step u_step (
         .clock (clock),
         .reset (reset),
         .in    (chain[i]),
         .out   (chain[i+1])
      );
   end

   qfi_round u_round (
      .clock           (clock),
      .reset           (reset),
      .in              (chain[DIV_STEPS]),
      .zero_offset     (offset_ff),
      .unsigned_result (unsigned_ff),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

   `QFI_ASSERT_DELAY(a_item_out, clock, reset, accept, LATENCY, rsp_valid)
   `QFI_ASSERT_IMPL(a_no_phantom, clock, reset, rsp_valid, $past(accept, LATENCY))
   `QFI_ASSERT_IMPL(a_final_kept, clock, reset, rsp_valid, rsp_data.final_result == $past(req_data.final_element, LATENCY))

endmodule

### sv/qfi_unpack.sv
// Input widening, operand classification and divider setup.
module qfi_unpack import qfi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     req_data,
   input  logic [1:0]  source_format,
   input  logic [31:0] scale_bits,
   output div_type     out
);

   logic        a_valid_ff, a_valid_in;
   logic        a_final_ff;
   logic [31:0] a_bits_ff, a_bits_in;
   div_type     b_ff, b_in;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [3:0]  top;
      logic [3:0]  shift;
      logic [9:0]  man2;
      logic [7:0]  e32;
      logic [31:0] r;
      ex  = h[14:10];
      man = h[9:0];
      top = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) top = 4'(i);
      end
      shift = 4'd10 - top;
      man2  = man << shift;
      e32   = 8'd103 + {4'd0, top};
      if (ex == 5'h1F) begin
         r = {h[15], 8'hFF, man, 13'd0};
      end else if (ex == 5'd0) begin
         if (man == 10'd0) r = {h[15], 31'd0};
         else r = {h[15], e32, man2, 13'd0};
      end else begin
         r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
      end
      return r;
   endfunction

   assign a_valid_in = in_valid;

   always_comb begin
      case (source_format)
         FMT_BF16: a_bits_in = {req_data.element_bits[15:0], 16'd0};
         FMT_HALF: a_bits_in = half_to_single(req_data.element_bits[15:0]);
         default:  a_bits_in = req_data.element_bits;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else a_valid_ff <= a_valid_in;
   end

   always_ff @(posedge clock) begin
      a_bits_ff  <= a_bits_in;
      a_final_ff <= req_data.final_element;
   end

   always_comb begin
      logic     nnan, ninf, nzero, dnan, dinf, dzero;
      norm_type nn, dn;
      nnan  = a_bits_ff[30:23] == 8'hFF && a_bits_ff[22:0] != 23'd0;
      ninf  = a_bits_ff[30:23] == 8'hFF && a_bits_ff[22:0] == 23'd0;
      nzero = a_bits_ff[30:0] == 31'd0;
      dnan  = scale_bits[30:23] == 8'hFF && scale_bits[22:0] != 23'd0;
      dinf  = scale_bits[30:23] == 8'hFF && scale_bits[22:0] == 23'd0;
      dzero = scale_bits[30:0] == 31'd0;
      nn = normalize(a_bits_ff[30:23], a_bits_ff[22:0]);
      dn = normalize(scale_bits[30:23], scale_bits[22:0]);
      b_in.valid      = a_valid_ff;
      b_in.final_flag = a_final_ff;
      b_in.sign       = a_bits_ff[31] ^ scale_bits[31];
      if (nnan || dnan || (nzero && dzero) || (ninf && dinf)) b_in.cls = CLS_ZERO;
      else if (ninf || dzero) b_in.cls = CLS_SAT;
      else if (nzero || dinf) b_in.cls = CLS_ZERO;
      else b_in.cls = CLS_FINITE;
      b_in.divisor = dn.mant;
      b_in.quot    = '0;
      if (nn.mant < dn.mant) begin
         b_in.rem      = {nn.mant, 1'b0};
         b_in.exponent = nn.exponent - dn.exponent - EXP_W'(1);
      end else begin
         b_in.rem      = {1'b0, nn.mant};
         b_in.exponent = nn.exponent - dn.exponent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_ff.valid <= 1'b0;
      else b_ff.valid <= b_in.valid;
      b_ff.final_flag <= b_in.final_flag;
      b_ff.sign       <= b_in.sign;
      b_ff.cls        <= b_in.cls;
      b_ff.exponent   <= b_in.exponent;
      b_ff.rem        <= b_in.rem;
      b_ff.divisor    <= b_in.divisor;
      b_ff.quot       <= b_in.quot;
   end

   assign out = b_ff;

endmodule

### sv/qfi_div_step.sv
// One restoring division step of the mantissa divider pipeline.
module qfi_div_step import qfi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  div_type in,
   output div_type out
);

   div_type             step_ff, step_in;
   logic [QUOT_W:0]     diff;
   logic                ge;
   logic [QUOT_W-1:0]   r_next;

   always_comb begin
      diff    = {1'b0, in.rem} - {2'b00, in.divisor};
      ge      = !diff[QUOT_W];
      r_next  = ge ? diff[QUOT_W-1:0] : in.rem;
      step_in = in;
      step_in.rem  = {r_next[QUOT_W-2:0], 1'b0};
      step_in.quot = {in.quot[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff.valid <= 1'b0;
      else step_ff.valid <= step_in.valid;
      step_ff.final_flag <= step_in.final_flag;
      step_ff.sign       <= step_in.sign;
      step_ff.cls        <= step_in.cls;
      step_ff.exponent   <= step_in.exponent;
      step_ff.rem        <= step_in.rem;
      step_ff.divisor    <= step_in.divisor;
      step_ff.quot       <= step_in.quot;
   end

   assign out = step_ff;

endmodule

### sv/qfi_round.sv
// Quotient rounding, integer conversion, offset and clamp.
module qfi_round import qfi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_type           in,
   input  logic signed [8:0] zero_offset,
   input  logic              unsigned_result,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   // stage 1: quotient rounded to single precision
   logic                    r1_valid_ff, r1_valid_in;
   logic                    r1_final_ff, r1_sign_ff;
   class_type               r1_cls_ff;
   logic [MANT_W-1:0]       r1_mant_ff, r1_mant_in;
   logic signed [EXP_W-1:0] r1_exp_ff, r1_exp_in;

   // stage 2: integer magnitude
   logic                    r2_valid_ff, r2_valid_in;
   logic                    r2_final_ff, r2_sign_ff;
   logic                    r2_sat_ff, r2_sat_in;
   logic                    r2_zero_ff, r2_zero_in;
   logic [30:0]             r2_mag_ff, r2_mag_in;

   // stage 3: output
   logic                    r3_valid_ff, r3_valid_in;
   rsp_type                 r3_data_ff, r3_data_in;

   always_comb begin
      logic [MANT_W-1:0] mant;
      logic              up;
      logic [MANT_W:0]   m25;
      mant = in.quot[QUOT_W-1:1];
      up   = in.quot[0] & ((in.rem != '0) | in.quot[1]);
      m25  = {1'b0, mant} + {{MANT_W{1'b0}}, up};
      r1_valid_in = in.valid;
      if (m25[MANT_W]) begin
         r1_mant_in = {1'b1, {(MANT_W-1){1'b0}}};
         r1_exp_in  = in.exponent + EXP_W'(1);
      end else begin
         r1_mant_in = m25[MANT_W-1:0];
         r1_exp_in  = in.exponent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) r1_valid_ff <= 1'b0;
      else r1_valid_ff <= r1_valid_in;
   end

   always_ff @(posedge clock) begin
      r1_final_ff <= in.final_flag;
      r1_sign_ff  <= in.sign;
      r1_cls_ff   <= in.cls;
      r1_mant_ff  <= r1_mant_in;
      r1_exp_ff   <= r1_exp_in;
   end

   always_comb begin
      logic [4:0]  shr;
      logic [2:0]  shl;
      logic [47:0] ext;
      logic [23:0] m;
      logic [23:0] frac;
      logic        up;
      shr  = 5'(EXP_W'(23) - r1_exp_ff);
      shl  = 3'(r1_exp_ff - EXP_W'(23));
      ext  = {r1_mant_ff, 24'd0} >> shr;
      m    = ext[47:24];
      frac = ext[23:0];
      up   = (frac > 24'h80_0000) || (frac == 24'h80_0000 && m[0]);
      r2_valid_in = r1_valid_ff;
      r2_sat_in   = r1_cls_ff == CLS_SAT ||
                    (r1_cls_ff == CLS_FINITE && r1_exp_ff >= EXP_W'(31));
      r2_zero_in  = r1_cls_ff == CLS_ZERO ||
                    (r1_cls_ff == CLS_FINITE && r1_exp_ff < -EXP_W'(1));
      if (r1_exp_ff >= EXP_W'(23)) r2_mag_in = 31'(r1_mant_ff) << shl;
      else r2_mag_in = 31'(m) + 31'(up);
   end

   always_ff @(posedge clock) begin
      if (reset) r2_valid_ff <= 1'b0;
      else r2_valid_ff <= r2_valid_in;
   end

   always_ff @(posedge clock) begin
      r2_final_ff <= r1_final_ff;
      r2_sign_ff  <= r1_sign_ff;
      r2_sat_ff   <= r2_sat_in;
      r2_zero_ff  <= r2_zero_in;
      r2_mag_ff   <= r2_mag_in;
   end

   always_comb begin
      logic signed [VAL_W-1:0] v;
      logic signed [VAL_W-1:0] sum;
      logic signed [VAL_W-1:0] lo;
      logic signed [VAL_W-1:0] hi;
      if (r2_zero_ff) v = '0;
      else if (r2_sat_ff) v = r2_sign_ff ? SAT_LOW : SAT_HIGH;
      else if (r2_sign_ff) v = -$signed({3'b000, r2_mag_ff});
      else v = $signed({3'b000, r2_mag_ff});
      sum = v + VAL_W'(zero_offset);
      lo  = unsigned_result ? '0 : SIGNED_LOW;
      hi  = unsigned_result ? UNSIGNED_HIGH : SIGNED_HIGH;
      if (sum < lo) sum = lo;
      if (sum > hi) sum = hi;
      r3_valid_in = r2_valid_ff;
      r3_data_in.quantized_byte = sum[7:0];
      r3_data_in.final_result   = r2_final_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) r3_valid_ff <= 1'b0;
      else r3_valid_ff <= r3_valid_in;
   end

   always_ff @(posedge clock) begin
      r3_data_ff <= r3_data_in;
   end

   assign rsp_valid = r3_valid_ff;
   assign rsp_data  = r3_data_ff;

endmodule

### dv/quantize_float_to_int8_checker.sv
// Checker for the float to int8 quantizer: predicts each result and compares it.
module quantize_float_to_int8_checker import qfi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   mismatches,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   logic [31:0]       scale_q;
   logic signed [8:0] offset_q;
   logic [1:0]        format_q;
   logic              unsigned_q;
   rsp_type           expected_bytes[$];

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0] hexp;
      logic [9:0] man;
      int         e32;
      hexp = h[14:10];
      man  = h[9:0];
      if (hexp == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
      if (hexp == 5'd0) begin
         if (man == 10'd0) return {h[15], 31'd0};
         e32 = 127 - 15 + 1;
         while (!man[9]) begin
            man = man << 1;
            e32--;
         end
         man = man << 1;
         return {h[15], 8'(e32 - 1), man, 13'd0};
      end
      return {h[15], 8'(hexp - 15 + 127), man, 13'd0};
   endfunction

   function automatic void unpack_single(input logic [31:0] b, output logic [23:0] m,
                                         output int e);
      if (b[30:23] == 8'd0) begin
         m = {1'b0, b[22:0]};
         e = -126;
         while (!m[23]) begin
            m = m << 1;
            e--;
         end
      end else begin
         m = {1'b1, b[22:0]};
         e = int'(b[30:23]) - 127;
      end
   endfunction

   // IEEE single division, round to nearest even
   function automatic logic [31:0] divide_single(input logic [31:0] n, input logic [31:0] d);
      logic        sign, n_nan, d_nan, n_inf, d_inf, guard, rest;
      logic [23:0] mn, md;
      logic [63:0] num, quo, kept;
      int          en, ed, ex2, p, big_e, s, biased;
      sign  = n[31] ^ d[31];
      n_nan = n[30:23] == 8'hFF && n[22:0] != 0;
      d_nan = d[30:23] == 8'hFF && d[22:0] != 0;
      n_inf = n[30:23] == 8'hFF && n[22:0] == 0;
      d_inf = d[30:23] == 8'hFF && d[22:0] == 0;
      if (d[30:0] == 0) begin
         if (n_nan || n[30:0] == 0) return QNAN;
         return {sign, 8'hFF, 23'd0};
      end
      if (n_nan || d_nan || (n_inf && d_inf)) return QNAN;
      if (n_inf) return {sign, 8'hFF, 23'd0};
      if (d_inf || n[30:0] == 0) return {sign, 31'd0};
      unpack_single(n, mn, en);
      unpack_single(d, md, ed);
      num = {14'd0, mn, 26'd0};
      quo = num / md;
      rest = (num % md) != 0;
      ex2 = en - ed - 26;
      p = 0;
      for (int i = 0; i < 64; i++) if (quo[i]) p = i;
      big_e = p + ex2;
      s = (big_e >= -126) ? p - 23 : -149 - ex2;
      if (s >= 63) return {sign, 31'd0};
      kept  = quo >> s;
      guard = quo[s-1];
      rest  = rest || ((quo & ((64'd1 << (s - 1)) - 1)) != 0);
      if (guard && (rest || kept[0])) kept++;
      if (big_e < -126) return {sign, kept[30:0]};
      biased = big_e + 127;
      if (kept[24]) begin
         kept = kept >> 1;
         biased++;
      end
      if (biased >= 255) return {sign, 8'hFF, 23'd0};
      return {sign, 8'(biased), kept[22:0]};
   endfunction

   // nearest integer, ties to even, saturated to 32 bits; NaN gives zero
   function automatic longint round_to_int(input logic [31:0] b);
      logic [7:0]  ex;
      logic [63:0] mag, rem, half;
      int          s;
      ex = b[30:23];
      if (ex == 8'hFF && b[22:0] != 0) return 0;
      if (ex >= 8'd158) return b[31] ? -64'sd2147483648 : 64'sd2147483647;
      if (ex == 8'd0) return 0;
      mag = {40'd0, 1'b1, b[22:0]};
      if (ex >= 8'd150) begin
         mag = mag << (ex - 150);
      end else begin
         s = 150 - int'(ex);
         if (s >= 25) return 0;
         rem  = mag & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         mag  = mag >> s;
         if (rem > half || (rem == half && mag[0])) mag++;
      end
      return b[31] ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic rsp_type quantize_element(input req_type item);
      logic [31:0] wide;
      longint      q, lo, hi;
      rsp_type     r;
      case (format_q)
         FMT_BF16: wide = {item.element_bits[15:0], 16'd0};
         FMT_HALF: wide = half_to_single(item.element_bits[15:0]);
         default:  wide = item.element_bits;
      endcase
      q  = round_to_int(divide_single(wide, scale_q)) + longint'(offset_q);
      lo = unsigned_q ? 0 : -128;
      hi = unsigned_q ? 255 : 127;
      if (q < lo) q = lo;
      if (q > hi) q = hi;
      r.quantized_byte = q[7:0];
      r.final_result   = item.final_element;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         scale_q    <= SCALE_RESET;
         offset_q   <= '0;
         format_q   <= FMT_SINGLE;
         unsigned_q <= 1'b0;
         expected_bytes.delete();
      end else begin
         if (start && !busy) expected_bytes.push_back(quantize_element(req_data));
         if (rsp_valid) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("result with no item pending");
            end else begin
               exp_r = expected_bytes.pop_front();
               if (rsp_data.quantized_byte !== exp_r.quantized_byte)
                  report_mismatch($sformatf("quantized_byte got %h expected %h",
                                            rsp_data.quantized_byte, exp_r.quantized_byte));
               if (rsp_data.final_result !== exp_r.final_result)
                  report_mismatch($sformatf("final_result got %b expected %b",
                                            rsp_data.final_result, exp_r.final_result));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCALE:    scale_q    <= csr_wdata;
               CSR_OFFSET:   offset_q   <= csr_wdata[8:0];
               CSR_FORMAT:   format_q   <= csr_wdata[1:0];
               CSR_UNSIGNED: unsigned_q <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_bytes.size();
   end

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

endmodule

### dv/tb_quantize_float_to_int8.sv
// Testbench top for the float to int8 quantizer: stimulus and verdict.
module tb_quantize_float_to_int8 import qfi_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 30;
   localparam int LIMIT   = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   int                   mismatches, outstanding;
   int                   cycles = 0;
   logic                 quiet = 1'b0;
   logic [1:0]           cur_format = FMT_SINGLE;
   logic [31:0]          cur_scale = SCALE_RESET;

   always #2 clock = ~clock;

   quantize_float_to_int8 i_dut (.*);

   quantize_float_to_int8_checker i_checker (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_element(input logic [31:0] bits, input logic fin);
      start    <= 1'b1;
      req_data <= '{element_bits: bits, final_element: fin};
      while (busy) @(negedge clock);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 16) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      #1;
      while (!csr_ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_FORMAT) cur_format = value[1:0];
      if (idx == CSR_SCALE) cur_scale = value;
   endtask

   // element with an exponent from three below to six above the scale's, so results land near the int8 range
   function automatic logic [31:0] shaped_element();
      int          e;
      logic [31:0] f;
      logic [15:0] h;
      e = int'(cur_scale[30:23]) + $urandom_range(0, 9) - 3;
      if (e < 1) e = 1;
      if (e > 254) e = 254;
      f = {1'($urandom), 8'(e), 23'($urandom)};
      if (cur_format == FMT_BF16) return {16'($urandom), f[31:16]};
      if (cur_format == FMT_HALF) begin
         e = e - 127 + 15;
         h = (e >= 1 && e <= 30) ? {f[31], 5'(e), f[22:13]} : 16'($urandom);
         return {16'($urandom), h};
      end
      return f;
   endfunction

   function automatic logic [31:0] pick_scale(input int k);
      logic [31:0] odd[7] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'h7FC0_0001,
                              32'h0000_0001, 32'h7F7F_FFFF, 32'hFF80_0000};
      case (k % 5)
         0: return SCALE_RESET;
         1, 2: return {1'($urandom), 8'($urandom_range(112, 135)), 23'($urandom)};
         3: return odd[$urandom_range(6)];
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] dir_single[18] = '{
         32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'h3FC0_0000, 32'h4020_0000,
         32'hBF00_0000, 32'h42FE_CCCD, 32'h42FF_0000, 32'hC301_0000, 32'hC302_0000,
         32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001,
         32'h4F40_0000, 32'hFFFF_FFFF, 32'h3F80_0000};
      logic [31:0] off;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_single[i]) send_element(dir_single[i], i[0]);
      write_reg(CSR_FORMAT, FMT_HALF);
      send_element(32'hFFFF_0001, 1'b1);
      send_element(32'h0000_7C00, 1'b0);
      send_element(32'h0000_7E00, 1'b1);
      write_reg(CSR_FORMAT, FMT_BF16);
      send_element(32'hABCD_4300, 1'b0);
      write_reg(CSR_SCALE, 32'h0000_0000);
      write_reg(CSR_UNSIGNED, 32'd1);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h0000_BF80, 1'b1);

      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_SCALE, pick_scale(ph));
         case (ph)
            0: off = 32'h0000_0100;
            1: off = 32'h0000_00FF;
            2: off = 32'd0;
            default: off = {23'($urandom), 9'($urandom)};
         endcase
         write_reg(CSR_OFFSET, off);
         write_reg(CSR_FORMAT, {30'($urandom), 2'(ph % 4)});
         write_reg(CSR_UNSIGNED, {31'($urandom), 1'((ph / 2) % 2)});
         quiet = (ph == 5);
         for (int n = 0; n < 85; n++)
            send_element(($urandom_range(99) < 70) ? shaped_element() : $urandom,
                         1'($urandom_range(7) == 0));
      end

      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
